@@ rtl/core/hiasd_pkg.sv @@
// ----------------------------------------------------------------------------
// hiasd_pkg
// Types and constants shared by the hold and idle shutdown detector.
// ----------------------------------------------------------------------------
package hiasd_pkg;

	// milliseconds per second and the width of a delay in milliseconds
	localparam int unsigned MS_PER_SEC = 1000;
	localparam int unsigned DELAY_MS_W = 18;	// 255 * 1000 < 2^18

	// APB register map
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		REG_START_STATE   = 2'd0,
		REG_DESIRED_STATE = 2'd1,
		REG_AUTO_DELAY    = 2'd2,
		REG_HOLD_DELAY    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [7:0] start_state;
		logic signed [7:0] desired_state;
		logic [7:0]        auto_delay_seconds;
		logic [7:0]        hold_delay_seconds;
	} cfg_t;

	typedef struct packed {
		logic signed [7:0] button_state;
		logic [31:0]       now_ms;
	} in_item_t;

	typedef struct packed {
		logic shutdown_armed;
		logic enter_sleep;
	} out_item_t;

	// delay in seconds to milliseconds, exact at full width
	function automatic logic [DELAY_MS_W-1:0] sec_to_ms(input logic [7:0] sec);
		logic [DELAY_MS_W-1:0] ms;
		ms = DELAY_MS_W'(sec) * DELAY_MS_W'(MS_PER_SEC);
		return ms;
	endfunction

endpackage

@@ rtl/core/hold_and_idle_shutdown_detector.sv @@
// ----------------------------------------------------------------------------
// hold_and_idle_shutdown_detector
// Arms shutdown on a long idle run or a held button combination.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one poll word: the
//   button code and the millisecond timestamp. Output channel
//   (out_valid/out_ready/out_data) returns one word per poll: the armed flag
//   after that poll and the enter_sleep pulse.
//   Path: a poll accepted into the input register is evaluated against the
//   tracking state and its result is loaded into the result register,
//   which drives out_valid.
//   Throughput: one poll per cycle while out_ready is high. The tracking state updates at the same
//   edge that loads the result register, so the next poll sees it at once.
//   Stall: when out_ready is low the result register holds; the input
//   register still takes one more poll, then in_ready drops until the
//   result is taken. No word is lost or repeated.
//   Reset (arst_n low): tracking, arm, hold and idle flags clear, both
//   registers empty, configuration returns to its defaults. Start times are
//   not reset; they are only read while their flag is set.
//   Configuration: APB, registers at 0x0, 0x4, 0x8, 0xC; write only while idle.
// ----------------------------------------------------------------------------
module hold_and_idle_shutdown_detector import hiasd_pkg::*; #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// poll words in
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	// result words out
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data
);

	cfg_t      cfg;
	in_item_t  data_s1;
	logic      valid_s1;
	out_item_t res_s2;
	logic      valid_s2;
	out_item_t res;
	logic      advance;

	hiasd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// advance the input word into the result register when that slot frees
	assign advance  = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready = ~valid_s1 | advance;

	hiasd_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.item   (data_s1),
		.res    (res)
	);

	// input register: hold a word until it is evaluated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	// result register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

@@ rtl/core/hiasd_regs.sv @@
// ----------------------------------------------------------------------------
// hiasd_regs
// APB configuration registers of the shutdown detector.
// ----------------------------------------------------------------------------
module hiasd_regs import hiasd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_state        <= 8'sd0;
			cfg_q.desired_state      <= 8'sd1;
			cfg_q.auto_delay_seconds <= 8'd10;
			cfg_q.hold_delay_seconds <= 8'd3;
		end else if (wr_en) begin
			case (idx)
				REG_START_STATE:   cfg_q.start_state        <= pwdata[7:0];
				REG_DESIRED_STATE: cfg_q.desired_state      <= pwdata[7:0];
				REG_AUTO_DELAY:    cfg_q.auto_delay_seconds <= pwdata[7:0];
				REG_HOLD_DELAY:    cfg_q.hold_delay_seconds <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_START_STATE:   prdata = {24'd0, cfg_q.start_state};
			REG_DESIRED_STATE: prdata = {24'd0, cfg_q.desired_state};
			REG_AUTO_DELAY:    prdata = {24'd0, cfg_q.auto_delay_seconds};
			REG_HOLD_DELAY:    prdata = {24'd0, cfg_q.hold_delay_seconds};
			default:           prdata = '0;
		endcase
	end

endmodule

@@ rtl/core/hiasd_core.sv @@
// ----------------------------------------------------------------------------
// hiasd_core
// Tracking state and next-state logic for one poll.
// ----------------------------------------------------------------------------
module hiasd_core import hiasd_pkg::*; #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      step,
	input  in_item_t  item,
	output out_item_t res
);

	localparam int unsigned CMP_W = (TIME_BITS > DELAY_MS_W) ? TIME_BITS : DELAY_MS_W;

	logic                 tracking_q, armed_q, hold_active_q, idle_active_q;
	logic [TIME_BITS-1:0] hold_start_q, idle_start_q;

	logic                 tracking_d, armed_d, hold_active_d, idle_active_d;
	logic [TIME_BITS-1:0] hold_start_d, idle_start_d;
	logic                 sleep_d;

	logic [TIME_BITS-1:0] now;
	logic [TIME_BITS-1:0] idle_diff, hold_diff;
	logic [CMP_W-1:0]     auto_ms, hold_ms;
	logic                 is_idle, is_desired, idle_fire;

	assign now        = TIME_BITS'(item.now_ms);
	assign idle_diff  = now - idle_start_q;
	assign hold_diff  = now - hold_start_q;
	assign auto_ms    = CMP_W'(sec_to_ms(cfg.auto_delay_seconds));
	assign hold_ms    = CMP_W'(sec_to_ms(cfg.hold_delay_seconds));
	assign is_idle    = (item.button_state == cfg.start_state);
	assign is_desired = (item.button_state == cfg.desired_state);
	assign idle_fire  = idle_active_q && (idle_start_q < now) &&
	                    (CMP_W'(idle_diff) > auto_ms);

	always_comb begin
		tracking_d    = tracking_q | is_idle;
		armed_d       = armed_q;
		hold_active_d = hold_active_q;
		idle_active_d = idle_active_q;
		hold_start_d  = hold_start_q;
		idle_start_d  = idle_start_q;
		sleep_d       = 1'b0;

		if (tracking_d) begin
			if (armed_q) begin
				// armed: wait for idle, then clear the hold, tracking and arm flags and sleep
				if (is_idle) begin
					hold_active_d = 1'b0;
					tracking_d    = 1'b0;
					armed_d       = 1'b0;
					sleep_d       = 1'b1;
				end
			end else begin
				if (idle_fire) begin
					idle_active_d = 1'b0;
					tracking_d    = 1'b0;
					armed_d       = 1'b1;
				end else if (is_idle) begin
					if (!idle_active_q) begin
						idle_start_d  = now;
						idle_active_d = 1'b1;
					end
				end else begin
					idle_active_d = 1'b0;
				end

				if (is_desired) begin
					if (hold_active_q) begin
						if (now < hold_start_q) begin
							hold_active_d = 1'b0;
						end else if (CMP_W'(hold_diff) >= hold_ms) begin
							tracking_d    = 1'b0;
							armed_d       = 1'b1;
							hold_active_d = 1'b0;
						end
					end else begin
						hold_start_d  = now;
						hold_active_d = 1'b1;
					end
				end else begin
					hold_active_d = 1'b0;
				end
			end
		end

		res.shutdown_armed = armed_d;
		res.enter_sleep    = sleep_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q    <= 1'b0;
			armed_q       <= 1'b0;
			hold_active_q <= 1'b0;
			idle_active_q <= 1'b0;
		end else if (step) begin
			tracking_q    <= tracking_d;
			armed_q       <= armed_d;
			hold_active_q <= hold_active_d;
			idle_active_q <= idle_active_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			hold_start_q <= hold_start_d;
			idle_start_q <= idle_start_d;
		end
	end

endmodule
